// File: hw/rtl/aset_pkg.sv
// ----------------------------------------------------------------------------
// aset_pkg
// shared types and constants of the step and energy tracker
// ----------------------------------------------------------------------------
`default_nettype none

package aset_pkg;

    // item modes
    typedef logic [2:0] t_mode;
    localparam t_mode MODE_SAMPLE = 3'd0;
    localparam t_mode MODE_MINUTE = 3'd1;
    localparam t_mode MODE_START  = 3'd2;
    localparam t_mode MODE_END    = 3'd3;
    localparam t_mode MODE_DAY    = 3'd4;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WEIGHT    = 2'd0;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd1;
    localparam t_cfg_idx CFG_RISE      = 2'd2;

    // serial square root: radicand and root widths
    localparam int SQ_IN_W  = 48;
    localparam int SQ_OUT_W = 24;
    localparam int SQ_REM_W = 26;
    localparam int SQ_CNT_W = 5;

    // serial divider: dividend and divisor widths
    localparam int DV_W     = 55;
    localparam int DS_W     = 26;
    localparam int DV_CNT_W = 6;

    // energy regression constants
    localparam logic [14:0]        LIN_K  = 15'd28195;
    localparam logic signed [40:0] LIN_OFS = 41'sd24922812416;
    localparam logic [DS_W-1:0]    KC_DIV = 26'd35200000;
    localparam logic [2:0]         WT_K   = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_RT_GO,
        ST_RT_WAIT,
        ST_OLD_SQ,
        ST_UPD,
        ST_MN_GO,
        ST_MN_WAIT,
        ST_RMS_GO,
        ST_RMS_WAIT,
        ST_LIN,
        ST_SCALE,
        ST_KC_GO,
        ST_KC_WAIT,
        ST_ACC,
        ST_CONV1,
        ST_CONV2,
        ST_DONE
    } t_state;

    // handshake between sequencer and a serial unit
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/aset_sqrt.sv
// ----------------------------------------------------------------------------
// aset_sqrt
// bit-serial floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aset_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [aset_pkg::SQ_IN_W-1:0]  i_radicand,
    output logic                               o_done,
    output logic [aset_pkg::SQ_OUT_W-1:0]      o_root
);

    logic [aset_pkg::SQ_IN_W-1:0]  r_rad;
    logic [aset_pkg::SQ_REM_W-1:0] r_rem;
    logic [aset_pkg::SQ_OUT_W-1:0] r_root;
    logic [aset_pkg::SQ_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [aset_pkg::SQ_REM_W+1:0] w_t;
    logic [aset_pkg::SQ_REM_W+1:0] w_trial;
    logic                          w_ge;

    assign w_t     = {r_rem, r_rad[aset_pkg::SQ_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= aset_pkg::SQ_CNT_W'(aset_pkg::SQ_OUT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == aset_pkg::SQ_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[aset_pkg::SQ_IN_W-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= aset_pkg::SQ_REM_W'(w_t - w_trial);
                r_root <= {r_root[aset_pkg::SQ_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_t[aset_pkg::SQ_REM_W-1:0];
                r_root <= {r_root[aset_pkg::SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hw/rtl/aset_div.sv
// ----------------------------------------------------------------------------
// aset_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aset_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [aset_pkg::DV_W-1:0]  i_dividend,
    input  wire logic [aset_pkg::DS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [aset_pkg::DV_W-1:0]       o_quotient
);

    logic [aset_pkg::DV_W-1:0]     r_dvd;
    logic [aset_pkg::DS_W-1:0]     r_dvs;
    logic [aset_pkg::DS_W-1:0]     r_rem;
    logic [aset_pkg::DV_W-1:0]     r_quo;
    logic [aset_pkg::DV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [aset_pkg::DS_W:0] w_t;
    logic                    w_ge;

    assign w_t  = {r_rem, r_dvd[aset_pkg::DV_W-1]};
    assign w_ge = (w_t >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= aset_pkg::DV_CNT_W'(aset_pkg::DV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == aset_pkg::DV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[aset_pkg::DV_W-2:0], 1'b0};
            r_quo <= {r_quo[aset_pkg::DV_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= aset_pkg::DS_W'(w_t - {1'b0, r_dvs});
            end else begin
                r_rem <= w_t[aset_pkg::DS_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/accel_step_and_energy_tracker.sv
// ----------------------------------------------------------------------------
// accel_step_and_energy_tracker
// step detector and per-minute energy tracker for a three-axis accelerometer
// ----------------------------------------------------------------------------
// One input beat is taken at a time; o_stall stays high from the accepting
// edge until the beat's result has been moved into the output register, then
// drops in the idle state, where the next beat can be taken. A sample beat
// runs three squares on a shared 17x17 multiplier, the start of the
// bit-serial square root, its 24 iterations and the done flag, the update of
// the magnitude window and the running sum of squares, the scaling of the
// energy totals, the load of the result and the idle state. A minute beat
// runs the bit-serial divider for the window mean, the square root for the
// rms, the divider again for the kcal scaling, and the unit starts,
// regression, accumulate, scaling, load and idle. Start, end, day-reset and
// unused modes go straight to the scaling of the totals, load and idle. A
// result still held by i_stall in the output register adds its wait to the
// next beat's load. The window needs no clearing pass: entries ahead of the
// write pointer read as zero until the pointer first wraps. The result
// register frees the input side, so a new beat is accepted while the last
// result still waits on i_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_step_and_energy_tracker #(
    parameter int WINDOW_LEN = 1800
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input items
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [2:0]          i_mode,
    input  wire logic signed [15:0]  i_accel_x,
    input  wire logic signed [15:0]  i_accel_y,
    input  wire logic signed [15:0]  i_accel_z,
    // results
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_step_seen,
    output logic [15:0]              o_magnitude,
    output logic signed [31:0]       o_energy_total_x100,
    output logic signed [31:0]       o_energy_exercise_x100,
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = 32 + $clog2(WINDOW_LEN);

    // configuration
    logic [9:0]  r_weight;
    logic [15:0] r_threshold;
    logic [15:0] r_rise;

    // sequencer
    aset_pkg::t_state r_state;
    aset_pkg::t_state n_state;
    aset_pkg::t_mode  r_mode;

    // latched beat
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;

    // tracker state
    logic [15:0]             r_win [WINDOW_LEN];
    logic [15:0]             r_rd;
    logic [PTR_W-1:0]        r_ptr;
    logic                    r_wrapped;
    logic [SUM_W-1:0]        r_sum;
    logic [15:0]             r_prev;
    logic signed [47:0]      r_e_total;
    logic signed [47:0]      r_e_exer;
    logic                    r_exercising;

    // working registers
    logic [31:0]             r_acc;
    logic [31:0]             r_oldsq;
    logic [15:0]             r_mag;
    logic                    r_step;
    logic [31:0]             r_mean;
    logic [23:0]             r_root;
    logic signed [40:0]      r_lin;
    logic signed [54:0]      r_n;
    logic signed [54:0]      r_p_total;
    logic signed [54:0]      r_p_exer;
    logic signed [31:0]      r_s_total;
    logic signed [31:0]      r_s_exer;

    // output register
    logic                    r_ov;
    logic                    r_o_step;
    logic [15:0]             r_o_mag;
    logic signed [31:0]      r_o_total;
    logic signed [31:0]      r_o_exer;

    // serial units
    aset_pkg::t_unit_ctl              w_rt;
    aset_pkg::t_unit_ctl              w_dv;
    logic [aset_pkg::SQ_IN_W-1:0]     w_rad;
    logic [aset_pkg::SQ_OUT_W-1:0]    w_root;
    logic [aset_pkg::DV_W-1:0]        w_dvd;
    logic [aset_pkg::DS_W-1:0]        w_dvs;
    logic [aset_pkg::DV_W-1:0]        w_quo;

    // shared multiplier
    logic signed [16:0] w_ma;
    logic signed [33:0] w_prod;
    logic [31:0]        w_sq;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_load_out;
    logic [15:0] w_old;
    logic [PTR_W:0] w_ptr_inc;
    logic        w_neg;
    logic [53:0] w_nabs;
    logic signed [31:0] w_d;
    logic signed [48:0] w_tot_sum;
    logic signed [48:0] w_exe_sum;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_acc  = r_ov && !i_stall;
    assign w_load_out = (r_state == aset_pkg::ST_DONE) && (!r_ov || !i_stall);
    assign o_stall    = (r_state != aset_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // saturate a 49-bit sum to the signed 48-bit range
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] res;
        if (v[48] != v[47]) begin
            res = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

    // energy times 100 over 65536, toward zero, clamped to 32 bits
    function automatic logic signed [31:0] to_x100(input logic signed [54:0] p);
        logic signed [54:0] adj;
        logic signed [54:0] sh;
        logic signed [31:0] res;
        adj = p[54] ? (p + 55'sd65535) : p;
        sh  = adj >>> 16;
        if (sh > 55'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (sh < -55'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = sh[31:0];
        end
        return res;
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= 10'd150;
            r_threshold <= 16'd4219;
            r_rise      <= 16'd205;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aset_pkg::CFG_WEIGHT:    r_weight    <= i_cfg_data[9:0];
                aset_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                aset_pkg::CFG_RISE:      r_rise      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            aset_pkg::ST_SQ_X:   w_ma = {r_x[15], r_x};
            aset_pkg::ST_SQ_Y:   w_ma = {r_y[15], r_y};
            aset_pkg::ST_SQ_Z:   w_ma = {r_z[15], r_z};
            aset_pkg::ST_OLD_SQ: w_ma = {1'b0, w_old};
            default:             w_ma = {1'b0, r_mag};
        endcase
    end
    assign w_prod = w_ma * w_ma;
    assign w_sq   = w_prod[31:0];

    // entries not yet written since reset read as zero
    assign w_old     = r_wrapped ? r_rd : 16'd0;
    assign w_ptr_inc = {1'b0, r_ptr} + 1'b1;

    // serial unit hookup
    assign w_rt.start = (r_state == aset_pkg::ST_RT_GO) || (r_state == aset_pkg::ST_RMS_GO);
    assign w_dv.start = (r_state == aset_pkg::ST_MN_GO) || (r_state == aset_pkg::ST_KC_GO);
    assign w_rad = (r_state == aset_pkg::ST_RT_GO) ? {16'd0, r_acc} : {r_mean, 16'd0};

    assign w_neg  = r_n[54];
    assign w_nabs = w_neg ? 54'(-r_n) : r_n[53:0];
    assign w_dvd  = (r_state == aset_pkg::ST_MN_GO) ? aset_pkg::DV_W'(r_sum)
                  : ({1'b0, w_nabs} + (w_neg ? aset_pkg::DV_W'(aset_pkg::KC_DIV - 1'b1)
                                             : aset_pkg::DV_W'(0)));
    assign w_dvs  = (r_state == aset_pkg::ST_MN_GO) ? aset_pkg::DS_W'(WINDOW_LEN)
                                                    : aset_pkg::KC_DIV;

    aset_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rt.start),
        .i_radicand (w_rad),
        .o_done     (w_rt.done),
        .o_root     (w_root)
    );

    aset_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dv.start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_dv.done),
        .o_quotient (w_quo)
    );

    // signed increment from the floored quotient
    assign w_d = w_neg ? -$signed({1'b0, w_quo[30:0]}) : $signed({1'b0, w_quo[30:0]});
    assign w_tot_sum = {r_e_total[47], r_e_total} + 49'(w_d);
    assign w_exe_sum = {r_e_exer[47], r_e_exer} + 49'(w_d);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aset_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_mode)
                        aset_pkg::MODE_SAMPLE: n_state = aset_pkg::ST_SQ_X;
                        aset_pkg::MODE_MINUTE: n_state = aset_pkg::ST_MN_GO;
                        default:               n_state = aset_pkg::ST_CONV1;
                    endcase
                end
            end
            aset_pkg::ST_SQ_X:     n_state = aset_pkg::ST_SQ_Y;
            aset_pkg::ST_SQ_Y:     n_state = aset_pkg::ST_SQ_Z;
            aset_pkg::ST_SQ_Z:     n_state = aset_pkg::ST_RT_GO;
            aset_pkg::ST_RT_GO:    n_state = aset_pkg::ST_RT_WAIT;
            aset_pkg::ST_RT_WAIT:  if (w_rt.done) n_state = aset_pkg::ST_OLD_SQ;
            aset_pkg::ST_OLD_SQ:   n_state = aset_pkg::ST_UPD;
            aset_pkg::ST_UPD:      n_state = aset_pkg::ST_CONV1;
            aset_pkg::ST_MN_GO:    n_state = aset_pkg::ST_MN_WAIT;
            aset_pkg::ST_MN_WAIT:  if (w_dv.done) n_state = aset_pkg::ST_RMS_GO;
            aset_pkg::ST_RMS_GO:   n_state = aset_pkg::ST_RMS_WAIT;
            aset_pkg::ST_RMS_WAIT: if (w_rt.done) n_state = aset_pkg::ST_LIN;
            aset_pkg::ST_LIN:      n_state = aset_pkg::ST_SCALE;
            aset_pkg::ST_SCALE:    n_state = aset_pkg::ST_KC_GO;
            aset_pkg::ST_KC_GO:    n_state = aset_pkg::ST_KC_WAIT;
            aset_pkg::ST_KC_WAIT:  if (w_dv.done) n_state = aset_pkg::ST_ACC;
            aset_pkg::ST_ACC:      n_state = aset_pkg::ST_CONV1;
            aset_pkg::ST_CONV1:    n_state = aset_pkg::ST_CONV2;
            aset_pkg::ST_CONV2:    n_state = aset_pkg::ST_DONE;
            aset_pkg::ST_DONE:     if (w_load_out) n_state = aset_pkg::ST_IDLE;
            default:               n_state = aset_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aset_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window memory: read old entry early, write new magnitude at update
    always_ff @(posedge i_clk) begin
        if (r_state == aset_pkg::ST_UPD) begin
            r_win[r_ptr] <= r_mag;
        end
        r_rd <= r_win[r_ptr];
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_wrapped    <= 1'b0;
            r_sum        <= '0;
            r_prev       <= '0;
            r_e_total    <= '0;
            r_e_exer     <= '0;
            r_exercising <= 1'b0;
        end else begin
            case (r_state)
                aset_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_mode)
                            aset_pkg::MODE_START: begin
                                r_exercising <= 1'b1;
                                r_e_exer     <= '0;
                            end
                            aset_pkg::MODE_END: r_exercising <= 1'b0;
                            aset_pkg::MODE_DAY: begin
                                r_e_total <= '0;
                                r_e_exer  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                aset_pkg::ST_UPD: begin
                    r_sum  <= r_sum - SUM_W'(r_oldsq) + SUM_W'(w_sq);
                    r_prev <= r_mag;
                    if (w_ptr_inc >= (PTR_W+1)'(WINDOW_LEN)) begin
                        r_ptr     <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_ptr <= w_ptr_inc[PTR_W-1:0];
                    end
                end
                aset_pkg::ST_ACC: begin
                    r_e_total <= sat48(w_tot_sum);
                    if (r_exercising) begin
                        r_e_exer <= sat48(w_exe_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= i_mode;
            r_x    <= i_accel_x;
            r_y    <= i_accel_y;
            r_z    <= i_accel_z;
            r_step <= 1'b0;
        end
        case (r_state)
            aset_pkg::ST_SQ_X:     r_acc <= w_sq;
            aset_pkg::ST_SQ_Y:     r_acc <= r_acc + w_sq;
            aset_pkg::ST_SQ_Z:     r_acc <= r_acc + w_sq;
            aset_pkg::ST_RT_WAIT:  if (w_rt.done) r_mag <= w_root[15:0];
            aset_pkg::ST_OLD_SQ:   r_oldsq <= w_sq;
            aset_pkg::ST_UPD: begin
                // strong rising crossing of the threshold
                r_step <= (r_mag > r_threshold) && (r_prev < r_threshold)
                       && ((17'(r_mag) - 17'(r_prev)) > 17'(r_rise));
            end
            aset_pkg::ST_MN_WAIT:  if (w_dv.done) r_mean <= w_quo[31:0];
            aset_pkg::ST_RMS_WAIT: if (w_rt.done) r_root <= w_root;
            aset_pkg::ST_LIN: begin
                r_lin <= $signed({1'b0, 40'(40'(r_root) * 40'(aset_pkg::LIN_K))})
                       - aset_pkg::LIN_OFS;
            end
            aset_pkg::ST_SCALE: begin
                r_n <= 55'(r_lin * $signed({1'b0, 13'(r_weight * aset_pkg::WT_K)}));
            end
            aset_pkg::ST_CONV1: begin
                r_p_total <= 55'(r_e_total * $signed(8'sd100));
                r_p_exer  <= 55'(r_e_exer * $signed(8'sd100));
            end
            aset_pkg::ST_CONV2: begin
                r_s_total <= to_x100(r_p_total);
                r_s_exer  <= to_x100(r_p_exer);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (w_out_acc) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_step  <= (r_mode == aset_pkg::MODE_SAMPLE) && r_step;
            r_o_mag   <= r_prev;
            r_o_total <= r_s_total;
            r_o_exer  <= r_s_exer;
        end
    end

    assign o_valid                = r_ov;
    assign o_step_seen            = r_o_step;
    assign o_magnitude            = r_o_mag;
    assign o_energy_total_x100    = r_o_total;
    assign o_energy_exercise_x100 = r_o_exer;

    // a serial unit finishes only while the sequencer waits for it
    a_rt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rt.done |-> (r_state == aset_pkg::ST_RT_WAIT || r_state == aset_pkg::ST_RMS_WAIT))
        else $error("square root finished outside a wait state");

    a_dv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv.done |-> (r_state == aset_pkg::ST_MN_WAIT || r_state == aset_pkg::ST_KC_WAIT))
        else $error("divider finished outside a wait state");

    // window pointer stays inside the window
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < WINDOW_LEN)
        else $error("window pointer out of range");

    // an accepted beat always starts work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != aset_pkg::ST_IDLE))
        else $error("accepted beat did not leave idle");

endmodule

`default_nettype wire
